>>> src/nonoverlap_pattern_search_top_macros.svh
// assertion macros for the non-overlapping pattern search block
// used by the top level only; expects clk and rst_n in scope
`ifndef NONOVERLAP_PATTERN_SEARCH_TOP_MACROS_SVH
`define NONOVERLAP_PATTERN_SEARCH_TOP_MACROS_SVH

// implication in the same cycle
`define NPS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication in the next cycle
`define NPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/nps_pkg.sv
// shared types, constants and helpers for the pattern search block
// no dependencies
package nps_pkg;

    localparam int MAX_PATTERN_BYTES = 8;
    localparam int MAX_TEXT_LENGTH   = 65536;
    localparam int POS_W             = 16;
    localparam int LEN_W             = 4;
    localparam int BYTE_W            = 8;
    localparam int PATTERN_W         = MAX_PATTERN_BYTES * BYTE_W;
    localparam int IDX_W             = $clog2(MAX_PATTERN_BYTES) > 0 ? $clog2(MAX_PATTERN_BYTES) : 1;
    localparam int CFG_INDEX_W       = 1;
    localparam int CFG_DATA_W        = 64;
    localparam int QUEUE_DEPTH       = 2;
    localparam int TOP_LIMIT         = MAX_TEXT_LENGTH > 65536 ? 65536 : MAX_TEXT_LENGTH;

    localparam logic [POS_W-1:0] TOP_POSITION = POS_W'(TOP_LIMIT - 1);

    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_BYTES  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 1'b1;

    // candidate match as seen by the window, before the overlap check
    typedef struct packed {
        logic             cand;
        logic [POS_W-1:0] start;
        logic [POS_W-1:0] end_pos;
        logic             last;
    } nps_entry_t;

    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] r;
        r = len;
        if (len == '0)
            r = LEN_W'(1);
        else if (len > LEN_W'(MAX_PATTERN_BYTES))
            r = LEN_W'(MAX_PATTERN_BYTES);
        return r;
    endfunction

endpackage

>>> src/nps_front.sv
// front end: takes text items, keeps the byte window and position, flags candidates
// depends on nps_pkg
module nps_front
    import nps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [BYTE_W-1:0]     text_byte,
    input  logic                  text_end,
    input  logic [PATTERN_W-1:0]  pattern,
    input  logic [LEN_W-1:0]      len,
    output nps_entry_t            entry
);

    logic [BYTE_W-1:0] win_reg [MAX_PATTERN_BYTES];
    logic [BYTE_W-1:0] win_next [MAX_PATTERN_BYTES];
    logic [LEN_W-1:0]  fill_reg, fill_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              window_ok;

    always_comb
    begin
        logic [IDX_W-1:0]  pidx;
        logic [BYTE_W-1:0] pb;
        win_next[0] = text_byte;
        for (int i = 1; i < MAX_PATTERN_BYTES; i++)
        begin
            win_next[i] = win_reg[i-1];
        end
        fill_next = (fill_reg < LEN_W'(MAX_PATTERN_BYTES)) ? fill_reg + LEN_W'(1) : fill_reg;
        pos_next  = (pos_reg < TOP_POSITION) ? pos_reg + POS_W'(1) : pos_reg;

        window_ok = 1'b1;
        for (int i = 0; i < MAX_PATTERN_BYTES; i++)
        begin
            pidx = IDX_W'(len - LEN_W'(1) - LEN_W'(i));
            pb   = pattern[pidx*BYTE_W +: BYTE_W];
            if ((LEN_W'(i) < len) && (win_next[i] != pb))
                window_ok = 1'b0;
        end

        entry.cand    = (pos_reg < TOP_POSITION) && (fill_next >= len) && window_ok;
        entry.start   = pos_reg + POS_W'(1) - POS_W'(len);
        entry.end_pos = pos_reg + POS_W'(1);
        entry.last    = text_end;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            for (int i = 0; i < MAX_PATTERN_BYTES; i++)
            begin
                win_reg[i] <= win_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            pos_reg  <= '0;
        end
        else if (push)
        begin
            if (text_end)
            begin
                fill_reg <= '0;
                pos_reg  <= '0;
            end
            else
            begin
                fill_reg <= fill_next;
                pos_reg  <= pos_next;
            end
        end
    end

endmodule

>>> src/nps_queue.sv
// short queue between the front and back ends
// depends on nps_pkg
module nps_queue
    import nps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  nps_entry_t wr_entry,
    output logic       full,
    input  logic       pop,
    output logic       rd_valid,
    output nps_entry_t rd_entry
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH) > 0 ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    nps_entry_t        mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_entry = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            count_reg <= count_next;
        end
    end

endmodule

>>> src/nps_back.sv
// back end: overlap check, found state and the output register
// depends on nps_pkg
module nps_back
    import nps_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_valid,
    input  nps_entry_t       rd_entry,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             match_here,
    output logic [POS_W-1:0] match_start,
    output logic             found_any,
    output logic [POS_W-1:0] last_start,
    output logic             end_echo
);

    logic             out_valid_reg;
    logic [POS_W-1:0] eas_reg;
    logic             any_reg;
    logic [POS_W-1:0] last_reg;
    logic             hit;

    logic             match_here_reg;
    logic [POS_W-1:0] match_start_reg;
    logic             found_any_reg;
    logic [POS_W-1:0] last_start_reg;
    logic             end_echo_reg;

    assign pop = rd_valid && (!out_valid_reg || !out_stall);
    assign hit = rd_entry.cand && (rd_entry.start >= eas_reg);

    assign out_valid   = out_valid_reg;
    assign match_here  = match_here_reg;
    assign match_start = match_start_reg;
    assign found_any   = found_any_reg;
    assign last_start  = last_start_reg;
    assign end_echo    = end_echo_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            match_here_reg  <= hit;
            match_start_reg <= hit ? rd_entry.start : '0;
            found_any_reg   <= any_reg | hit;
            last_start_reg  <= hit ? rd_entry.start : last_reg;
            end_echo_reg    <= rd_entry.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            eas_reg       <= '0;
            any_reg       <= 1'b0;
            last_reg      <= '0;
        end
        else
        begin
            if (pop)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (pop)
            begin
                if (rd_entry.last)
                begin
                    eas_reg  <= '0;
                    any_reg  <= 1'b0;
                    last_reg <= '0;
                end
                else if (hit)
                begin
                    eas_reg  <= rd_entry.end_pos;
                    any_reg  <= 1'b1;
                    last_reg <= rd_entry.start;
                end
            end
        end
    end

endmodule

>>> src/nonoverlap_pattern_search_top.sv
// top level of the streaming non-overlapping pattern search
// depends on nps_pkg, nps_front, nps_queue, nps_back and the macros header
//
// usage:
//   write pattern_bytes (index 0, first character in the low byte) and
//   pattern_length (index 1, 1 to 8) on the cfg port while the block is idle
//   text items enter on in_valid / in_stall: text_byte plus text_end on the
//   final byte of a text; each item gives exactly one result item on
//   out_valid / out_stall
//   a result flags a match ending at that byte, its start, whether any match
//   was seen in this text, and the start of the last one
//   an accepted item passes the queue and then the output register; throughput
//   is one item per cycle when not stalled, set by the combinational window compare
//   in the front end; a two-entry queue sits between the front and back ends, so a stall on
//   the result side holds results in the output register and the queue;
//   in_stall rises only when the queue is full
//   reset clears all per-text state, sets pattern_length to 1 and
//   pattern_bytes to 0; per-text state also clears after the text_end item
`include "nonoverlap_pattern_search_top_macros.svh"

module nonoverlap_pattern_search_top
    import nps_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [BYTE_W-1:0]      text_byte,
    input  logic                   text_end,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   match_here,
    output logic [POS_W-1:0]       match_start,
    output logic                   found_any,
    output logic [POS_W-1:0]       last_start,
    output logic                   end_echo
);

    logic [PATTERN_W-1:0] pattern_bytes_reg;
    logic [LEN_W-1:0]     pattern_length_reg;
    logic [LEN_W-1:0]     len;
    logic                 push;
    logic                 q_full;
    logic                 q_valid;
    logic                 q_pop;
    nps_entry_t           wr_entry;
    nps_entry_t           rd_entry;

    assign len      = eff_len(pattern_length_reg);
    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bytes_reg  <= '0;
            pattern_length_reg <= LEN_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PATTERN_BYTES:  pattern_bytes_reg  <= PATTERN_W'(cfg_data);
                REG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    nps_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .text_byte (text_byte),
        .text_end  (text_end),
        .pattern   (pattern_bytes_reg),
        .len       (len),
        .entry     (wr_entry)
    );

    nps_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (wr_entry),
        .full     (q_full),
        .pop      (q_pop),
        .rd_valid (q_valid),
        .rd_entry (rd_entry)
    );

    nps_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .rd_valid    (q_valid),
        .rd_entry    (rd_entry),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .match_here  (match_here),
        .match_start (match_start),
        .found_any   (found_any),
        .last_start  (last_start),
        .end_echo    (end_echo)
    );

    `NPS_ASSERT_NOW(a_match_sets_found, out_valid && match_here, found_any, "match without found_any")
    `NPS_ASSERT_NOW(a_match_is_last, out_valid && match_here, last_start == match_start, "last_start differs from match_start")
    `NPS_ASSERT_NOW(a_no_match_zero, out_valid && !match_here, match_start == '0, "match_start not zero without match")
    `NPS_ASSERT_NEXT(a_pop_fills_out, q_pop, out_valid, "popped item did not reach the output register")

endmodule
